[hdl/assert_macros.svh]
// Assertion macros used by the checker file of this project.
// Each macro expands to one labeled concurrent assertion clocked on clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define FPR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every rising edge, reset included.
`define FPR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

[hdl/fpr_pkg.sv]
// ----------------------------------------------------------------------------
// fpr_pkg
// Types and constants of the report frame parser: frame layout, status and
// command codes, setting ranges and the descriptor passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package fpr_pkg;

   localparam int FRAME_LEN = 12;
   localparam int IDX_W     = 4;

   localparam logic [IDX_W-1:0] IDX_LAST_BYTE = IDX_W'(FRAME_LEN - 1);
   localparam logic [IDX_W-1:0] IDX_MAX       = {IDX_W{1'b1}};

   localparam logic [15:0] WORD_HEAD = 16'h55AA;
   localparam logic [15:0] WORD_TAIL = 16'h55BB;

   // Result status codes.
   localparam logic [1:0] ST_ACCEPTED  = 2'd0;
   localparam logic [1:0] ST_BAD_LEN   = 2'd1;
   localparam logic [1:0] ST_BAD_FRAME = 2'd2;
   localparam logic [1:0] ST_BAD_SUM   = 2'd3;

   // Command words.
   localparam logic [15:0] CMD_MODE     = 16'h0082;
   localparam logic [15:0] CMD_TRIGGER  = 16'h0083;
   localparam logic [15:0] CMD_CURRENT  = 16'h0084;
   localparam logic [15:0] CMD_POSTFLOW = 16'h0085;
   localparam logic [15:0] CMD_FORCE    = 16'h0086;
   localparam logic [15:0] CMD_UNIT     = 16'h0087;
   localparam logic [15:0] CMD_ALARM    = 16'h0088;
   localparam logic [15:0] CMD_VOLTS    = 16'h0089;
   localparam logic [15:0] CMD_OVERCUR  = 16'h8100;

   // Reset values of the settings.
   localparam logic [15:0] RST_DEVICE   = 16'h0002;
   localparam logic [1:0]  RST_MODE     = 2'd0;
   localparam logic        RST_TRIGGER  = 1'b0;
   localparam logic [5:0]  RST_CURRENT  = 6'd30;
   localparam logic [3:0]  RST_POSTFLOW = 4'd6;
   localparam logic [3:0]  RST_FORCE    = 4'd8;
   localparam logic [1:0]  RST_UNIT     = 2'd0;
   localparam logic [1:0]  RST_ALARM    = 2'd0;
   localparam logic [7:0]  RST_VOLTS    = 8'd220;

   localparam logic [1:0]  ALARM_OVERCUR = 2'd1;
   localparam logic [7:0]  VOLTS_LOW     = 8'd120;
   localparam logic [7:0]  VOLTS_HIGH    = 8'd240;

   // One classified frame on its way to the settings logic.
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] device;
      logic [15:0] command;
      logic [15:0] data;
   } fpr_desc_type;

endpackage

`default_nettype wire

[hdl/fpr_front.sv]
// ----------------------------------------------------------------------------
// fpr_front
// Collects frame bytes, counts them and classifies the frame on its last
// byte. A classified frame leaves as one descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [7:0]           rx_byte,
   input  wire logic                 end_of_frame,
   output logic                      push,
   output fpr_pkg::fpr_desc_type     push_desc
);
   import fpr_pkg::*;

   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic [7:0]       store_ff [FRAME_LEN];

   logic [15:0] head_word;
   logic [15:0] tail_word;
   logic [15:0] cmd_word;
   logic [15:0] data_word;
   logic [15:0] sum_word;
   logic [15:0] check_word;

   always_comb begin
      idx_in = idx_ff;
      if (accept) begin
         if (end_of_frame) begin
            idx_in = '0;
         end else if (idx_ff != IDX_MAX) begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (idx_ff < IDX_W'(FRAME_LEN))) begin
         store_ff[idx_ff] <= rx_byte;
      end
   end

   // The final byte is still on the input, so the tail word takes it from there.
   assign head_word  = {store_ff[0], store_ff[1]};
   assign tail_word  = {store_ff[10], rx_byte};
   assign cmd_word   = {store_ff[4], store_ff[5]};
   assign data_word  = {store_ff[6], store_ff[7]};
   assign check_word = {store_ff[8], store_ff[9]};
   assign sum_word   = cmd_word + data_word;

   always_comb begin
      if (idx_ff != IDX_LAST_BYTE) begin
         push_desc.status = ST_BAD_LEN;
      end else if ((head_word != WORD_HEAD) || (tail_word != WORD_TAIL)) begin
         push_desc.status = ST_BAD_FRAME;
      end else if (sum_word != check_word) begin
         push_desc.status = ST_BAD_SUM;
      end else begin
         push_desc.status = ST_ACCEPTED;
      end
      push_desc.device  = {store_ff[2], store_ff[3]};
      push_desc.command = cmd_word;
      push_desc.data    = data_word;
   end

   assign push = accept && end_of_frame;

endmodule

`default_nettype wire

[hdl/fpr_queue.sv]
// ----------------------------------------------------------------------------
// fpr_queue
// Two-entry queue of frame descriptors between the parser front and the
// settings back.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire fpr_pkg::fpr_desc_type push_desc,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      pop_valid,
   output fpr_pkg::fpr_desc_type     pop_desc
);
   import fpr_pkg::*;

   fpr_desc_type entries_ff [2];
   logic         wr_ptr_ff;
   logic         wr_ptr_in;
   logic         rd_ptr_ff;
   logic         rd_ptr_in;
   logic [1:0]   count_ff;
   logic [1:0]   count_in;
   logic         do_push;
   logic         do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_desc  = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

[hdl/fpr_back.sv]
// ----------------------------------------------------------------------------
// fpr_back
// Applies accepted frames to the setting registers and presents one result
// item per frame. The setting registers double as the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 desc_valid,
   input  wire fpr_pkg::fpr_desc_type desc,
   output logic                      desc_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [15:0]               rsp_device_kind,
   output logic [1:0]                rsp_weld_mode,
   output logic                      rsp_trigger_mode,
   output logic [5:0]                rsp_current_amps,
   output logic [3:0]                rsp_postflow_secs,
   output logic [3:0]                rsp_arc_force,
   output logic [1:0]                rsp_pressure_scale,
   output logic [1:0]                rsp_alarm_code,
   output logic [7:0]                rsp_mains_volts
);
   import fpr_pkg::*;

   function automatic logic [15:0] clamp_word(input logic [15:0] value,
                                              input logic [15:0] lo,
                                              input logic [15:0] hi);
      logic [15:0] result;
      result = value;
      if (value < lo) begin
         result = lo;
      end else if (value > hi) begin
         result = hi;
      end
      return result;
   endfunction

   logic        valid_ff;
   logic [1:0]  status_ff;
   logic [15:0] device_ff;
   logic [1:0]  mode_ff;
   logic        trigger_ff;
   logic [5:0]  current_ff;
   logic [3:0]  postflow_ff;
   logic [3:0]  force_ff;
   logic [1:0]  unit_ff;
   logic [1:0]  alarm_ff;
   logic [7:0]  volts_ff;

   logic [15:0] mode_clamp;
   logic [15:0] trigger_clamp;
   logic [15:0] current_clamp;
   logic [15:0] postflow_clamp;
   logic [15:0] force_clamp;
   logic [15:0] unit_clamp;
   logic [15:0] alarm_clamp;
   logic        apply;

   // A new frame moves in whenever the output slot is empty or being taken.
   assign desc_pop = desc_valid && (!valid_ff || !rsp_stall);
   assign apply    = desc_pop && (desc.status == ST_ACCEPTED);

   assign mode_clamp     = clamp_word(desc.data, 16'd0, 16'd2);
   assign trigger_clamp  = clamp_word(desc.data, 16'd0, 16'd1);
   assign current_clamp  = clamp_word(desc.data, 16'd15, 16'd50);
   assign postflow_clamp = clamp_word(desc.data, 16'd3, 16'd15);
   assign force_clamp    = clamp_word(desc.data, 16'd3, 16'd15);
   assign unit_clamp     = clamp_word(desc.data, 16'd0, 16'd2);
   assign alarm_clamp    = clamp_word(desc.data, 16'd0, 16'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (desc_pop) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (desc_pop) begin
         status_ff <= desc.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_ff   <= RST_DEVICE;
         mode_ff     <= RST_MODE;
         trigger_ff  <= RST_TRIGGER;
         current_ff  <= RST_CURRENT;
         postflow_ff <= RST_POSTFLOW;
         force_ff    <= RST_FORCE;
         unit_ff     <= RST_UNIT;
         alarm_ff    <= RST_ALARM;
         volts_ff    <= RST_VOLTS;
      end else if (apply) begin
         device_ff <= desc.device;
         unique case (desc.command)
            CMD_MODE:     mode_ff     <= mode_clamp[1:0];
            CMD_TRIGGER:  trigger_ff  <= trigger_clamp[0];
            CMD_CURRENT:  current_ff  <= current_clamp[5:0];
            CMD_POSTFLOW: postflow_ff <= postflow_clamp[3:0];
            CMD_FORCE:    force_ff    <= force_clamp[3:0];
            CMD_UNIT:     unit_ff     <= unit_clamp[1:0];
            CMD_ALARM:    alarm_ff    <= alarm_clamp[1:0];
            CMD_VOLTS:    volts_ff    <= (desc.data == 16'd0) ? VOLTS_LOW : VOLTS_HIGH;
            CMD_OVERCUR:  alarm_ff    <= ALARM_OVERCUR;
            default:      ;
         endcase
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_device_kind    = device_ff;
   assign rsp_weld_mode      = mode_ff;
   assign rsp_trigger_mode   = trigger_ff;
   assign rsp_current_amps   = current_ff;
   assign rsp_postflow_secs  = postflow_ff;
   assign rsp_arc_force      = force_ff;
   assign rsp_pressure_scale = unit_ff;
   assign rsp_alarm_code     = alarm_ff;
   assign rsp_mains_volts    = volts_ff;

endmodule

`default_nettype wire

[hdl/framed_report_parser_core.sv]
// ----------------------------------------------------------------------------
// framed_report_parser_core
// Byte-serial report frame parser with a settings register file.
// ----------------------------------------------------------------------------
// The core takes one frame byte per cycle while req_stall is low and returns
// one result item for every byte flagged as end of frame, once its descriptor
// has passed the queue and the result register. A frame is twelve bytes; its
// length, head and tail words and checksum are checked in that order, and a
// good frame updates the device type and at most one setting. The parser front
// classifies frames at full byte rate and hands them via a two-entry queue to
// the settings back; bytes stall only when it is full, as results are held off.
`default_nettype none

module framed_report_parser_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_end_of_frame,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_device_kind,
   output logic [1:0]       rsp_weld_mode,
   output logic             rsp_trigger_mode,
   output logic [5:0]       rsp_current_amps,
   output logic [3:0]       rsp_postflow_secs,
   output logic [3:0]       rsp_arc_force,
   output logic [1:0]       rsp_pressure_scale,
   output logic [1:0]       rsp_alarm_code,
   output logic [7:0]       rsp_mains_volts
);
   import fpr_pkg::*;

   logic         accept;
   logic         push;
   fpr_desc_type push_desc;
   logic         queue_full;
   logic         pop;
   logic         pop_valid;
   fpr_desc_type pop_desc;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   fpr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req_rx_byte),
      .end_of_frame (req_end_of_frame),
      .push         (push),
      .push_desc    (push_desc)
   );

   fpr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_desc  (pop_desc)
   );

   fpr_back u_back (
      .clock              (clock),
      .reset              (reset),
      .desc_valid         (pop_valid),
      .desc               (pop_desc),
      .desc_pop           (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_device_kind    (rsp_device_kind),
      .rsp_weld_mode      (rsp_weld_mode),
      .rsp_trigger_mode   (rsp_trigger_mode),
      .rsp_current_amps   (rsp_current_amps),
      .rsp_postflow_secs  (rsp_postflow_secs),
      .rsp_arc_force      (rsp_arc_force),
      .rsp_pressure_scale (rsp_pressure_scale),
      .rsp_alarm_code     (rsp_alarm_code),
      .rsp_mains_volts    (rsp_mains_volts)
   );

endmodule

`default_nettype wire

[hdl/fpr_checker.sv]
// ----------------------------------------------------------------------------
// fpr_checker
// Port-level checks of the report frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fpr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [7:0]  req_rx_byte,
   input wire logic        req_end_of_frame,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_status,
   input wire logic [15:0] rsp_device_kind,
   input wire logic [1:0]  rsp_weld_mode,
   input wire logic        rsp_trigger_mode,
   input wire logic [5:0]  rsp_current_amps,
   input wire logic [3:0]  rsp_postflow_secs,
   input wire logic [3:0]  rsp_arc_force,
   input wire logic [1:0]  rsp_pressure_scale,
   input wire logic [1:0]  rsp_alarm_code,
   input wire logic [7:0]  rsp_mains_volts
);

   // A held result keeps its item, settings included.
   `FPR_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_device_kind) && $stable(rsp_current_amps) && $stable(rsp_alarm_code)), "held result item changed")

   // Settings never leave their clamped ranges.
   `FPR_ASSERT(a_setting_range, rsp_valid |-> ((rsp_weld_mode != 2'd3) && (rsp_current_amps >= 6'd15) && (rsp_current_amps <= 6'd50) && (rsp_postflow_secs >= 4'd3) && (rsp_arc_force >= 4'd3) && (rsp_pressure_scale != 2'd3) && (rsp_alarm_code != 2'd3)), "setting out of range")

   // The supply voltage only takes its three legal values.
   `FPR_ASSERT(a_volts_legal, rsp_valid |-> ((rsp_mains_volts == 8'd120) || (rsp_mains_volts == 8'd220) || (rsp_mains_volts == 8'd240)), "illegal mains voltage")

   // No result item survives a reset.
   `FPR_ASSERT_ALWAYS(a_reset_clears, $fell(reset) |-> !rsp_valid, "result valid right after reset")

   logic unused_inputs;
   assign unused_inputs = req_valid ^ req_stall ^ (^req_rx_byte) ^ req_end_of_frame ^
                          rsp_trigger_mode;

endmodule

bind framed_report_parser_core fpr_checker u_fpr_checker (.*);

`default_nettype wire
